[design/mi_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mi_pkg
// Shared types for the modular inverse block.
// ----------------------------------------------------------------------------
package mi_pkg;

    // control broadcast to every remainder cell
    typedef struct packed {
        logic clr;  // zero the partial remainder
        logic en;   // take one shift/subtract step
    } t_cell_ctl;

endpackage
`default_nettype wire

[design/mi_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mi_cell
// One bit of the divider remainder: shift-in, subtract bit, borrow ripple.
// ----------------------------------------------------------------------------
module mi_cell (
    input  wire logic              i_clk,
    input  wire mi_pkg::t_cell_ctl i_ctl,
    input  wire logic              i_shift_in,
    input  wire logic              i_div_bit,
    input  wire logic              i_borrow_in,
    input  wire logic              i_sel,
    output logic                   o_rem,
    output logic                   o_next,
    output logic                   o_borrow
);
    import mi_pkg::*;

    logic r_rem;
    logic w_diff;

    assign w_diff   = i_shift_in ^ i_div_bit ^ i_borrow_in;
    assign o_borrow = (~i_shift_in & i_div_bit) | (~(i_shift_in ^ i_div_bit) & i_borrow_in);
    assign o_next   = i_sel ? w_diff : i_shift_in;
    assign o_rem    = r_rem;

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_rem <= 1'b0;
        end else if (i_ctl.en) begin
            r_rem <= o_next;
        end
    end

endmodule
`default_nettype wire

[design/mi_chain.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mi_chain
// Row of remainder cells forming a restoring divider, one quotient bit per step.
// ----------------------------------------------------------------------------
module mi_chain #(
    parameter int WIDTH = 32
) (
    input  wire logic              i_clk,
    input  wire mi_pkg::t_cell_ctl i_ctl,
    input  wire logic              i_dividend_msb,
    input  wire logic [WIDTH-1:0]  i_divisor,
    output logic                   o_qbit,
    output logic [WIDTH-1:0]       o_rem
);
    import mi_pkg::*;

    logic [WIDTH:0] w_rem;
    logic [WIDTH:0] w_next;
    logic [WIDTH:0] w_shift;
    logic [WIDTH:0] w_div;
    logic [WIDTH+1:0] w_borrow;
    logic           w_sel;

    assign w_shift   = {w_rem[WIDTH-1:0], i_dividend_msb};
    assign w_div     = {1'b0, i_divisor};
    assign w_borrow[0] = 1'b0;
    assign w_sel     = ~w_borrow[WIDTH+1];
    assign o_qbit    = w_sel;
    // remainder after the current step; it always fits in WIDTH bits
    assign o_rem     = w_next[WIDTH-1:0];

    for (genvar g = 0; g <= WIDTH; g++) begin : g_cell
        mi_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (i_ctl),
            .i_shift_in  (w_shift[g]),
            .i_div_bit   (w_div[g]),
            .i_borrow_in (w_borrow[g]),
            .i_sel       (w_sel),
            .o_rem       (w_rem[g]),
            .o_next      (w_next[g]),
            .o_borrow    (w_borrow[g+1])
        );
    end

endmodule
`default_nettype wire

[design/modular_inverse.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modular_inverse
// Modular inverse by the iterative extended Euclidean algorithm.
// ----------------------------------------------------------------------------
// Takes a value and a modulus (both cut to WIDTH bits) and returns the
// inverse of the value mod the modulus, or status 1 with inverse 0 when the
// two are not coprime, the value is zero, or the modulus is below two. One
// word is worked at a time. Each Euclid step runs the quotient through a row
// of WIDTH+1 bit cells, one quotient bit a cycle, after a check in the
// S_CHK state. The Euclid step count is at most about 1.44 * WIDTH. A
// finished result sits in the output register, and the next word is
// taken while it waits.
// ----------------------------------------------------------------------------
module modular_inverse #(
    parameter int WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_value,
    input  wire logic [31:0] i_modulus,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_inverse,
    output logic             o_status
);
    import mi_pkg::*;

    localparam int CW = $clog2(WIDTH);

    typedef enum logic [1:0] {S_IDLE, S_CHK, S_DIV, S_FIN} t_state;

    t_state           r_state;
    logic [WIDTH-1:0] r_mod, r_r, r_nr, r_t, r_nt, r_acc, r_dvd;
    logic             r_odd;
    logic [CW-1:0]    r_cnt;
    logic [WIDTH-1:0] r_res_inv;
    logic             r_res_stat;
    logic             r_out_valid;
    logic [31:0]      r_out_inv;
    logic             r_out_stat;

    logic [WIDTH-1:0] w_val, w_mod, w_rem, w_res_inv;
    logic [31:0]      w_res_out;
    logic             w_qbit;
    t_cell_ctl        w_ctl;

    // cut or zero-extend the 32-bit fields to the operand width
    always_comb begin
        for (int i = 0; i < WIDTH; i++) begin
            w_val[i] = (i < 32) ? i_value[i % 32]   : 1'b0;
            w_mod[i] = (i < 32) ? i_modulus[i % 32] : 1'b0;
        end
        w_res_inv = (r_odd || r_t == '0) ? r_t : r_mod - r_t;
        for (int i = 0; i < 32; i++) begin
            w_res_out[i] = (i < WIDTH) ? r_res_inv[i % WIDTH] : 1'b0;
        end
    end

    assign w_ctl.clr = (r_state == S_CHK);
    assign w_ctl.en  = (r_state == S_DIV);

    // quotient of r / nr, one bit a cycle, remainder left in the cells
    mi_chain #(.WIDTH(WIDTH)) u_chain (
        .i_clk          (i_clk),
        .i_ctl          (w_ctl),
        .i_dividend_msb (r_dvd[WIDTH-1]),
        .i_divisor      (r_nr),
        .o_qbit         (w_qbit),
        .o_rem          (w_rem)
    );

    assign o_stall   = (r_state != S_IDLE);
    assign o_valid   = r_out_valid;
    assign o_inverse = r_out_inv;
    assign o_status  = r_out_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // FIN reloads the output itself when it frees up
            if (r_out_valid && !i_stall && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        // a modulus below two runs no steps and ends with gcd 0
                        if (w_mod < WIDTH'(2)) begin
                            r_r  <= '0;
                            r_nr <= '0;
                        end else begin
                            r_r  <= w_mod;
                            r_nr <= w_val;
                        end
                        r_mod   <= w_mod;
                        r_t     <= '0;
                        r_nt    <= WIDTH'(1);
                        r_odd   <= 1'b0;
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (r_nr == '0) begin
                        r_res_stat <= (r_r != WIDTH'(1));
                        r_res_inv  <= (r_r != WIDTH'(1)) ? '0 : w_res_inv;
                        r_state    <= S_FIN;
                    end else begin
                        r_dvd   <= r_r;
                        r_acc   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_dvd <= {r_dvd[WIDTH-2:0], 1'b0};
                    // q * nt built MSB first alongside the quotient bits
                    r_acc <= {r_acc[WIDTH-2:0], 1'b0} + (w_qbit ? r_nt : '0);
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(WIDTH - 1)) begin
                        // last quotient bit is in: Euclid update
                        r_r     <= r_nr;
                        r_nr    <= w_rem;
                        r_t     <= r_nt;
                        r_nt    <= r_t + ({r_acc[WIDTH-2:0], 1'b0} + (w_qbit ? r_nt : '0));
                        r_odd   <= ~r_odd;
                        r_state <= S_CHK;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_inv   <= w_res_out;
                        r_out_stat  <= r_res_stat;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

[test/modular_inverse_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_inverse_checker
// Watches both channels, predicts each inverse and compares it.
// ----------------------------------------------------------------------------
module modular_inverse_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic        i_stall_in,
    input  wire logic [31:0] i_value,
    input  wire logic [31:0] i_modulus,
    input  wire logic        i_ovalid,
    input  wire logic        i_ostall,
    input  wire logic [31:0] i_inverse,
    input  wire logic        i_status,
    output int               o_errors,
    output int               o_pending
);

    typedef struct packed {
        logic [31:0] inverse;
        logic        status;
    } t_inv_result;

    t_inv_result inverse_queue[$];

    // Euclid with coefficient magnitudes and step parity
    function automatic t_inv_result invert_mod(logic [31:0] a, logic [31:0] m);
        t_inv_result res;
        logic [63:0] r, nr, t, nt, q, tmp;
        logic odd;
        res = '0;
        if (m < 2) begin
            res.status = 1'b1;
            return res;
        end
        r = m;
        nr = a;
        t = 0;
        nt = 1;
        odd = 1'b0;
        while (nr != 0) begin
            q = r / nr;
            tmp = t + q * nt;
            t = nt;
            nt = tmp;
            tmp = r - q * nr;
            r = nr;
            nr = tmp;
            odd = !odd;
        end
        if (r != 1) begin
            res.status = 1'b1;
        end else begin
            res.inverse = (odd || t == 0) ? t[31:0] : m - t[31:0];
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_inv_result want;
        int bad;
        bad = 0;
        if (!i_rst_n) begin
            o_errors <= 0;
            o_pending <= 0;
        end else begin
            if (i_valid && !i_stall_in)
                inverse_queue.push_back(invert_mod(i_value, i_modulus));
            if (i_ovalid && !i_ostall) begin
                if (inverse_queue.size() == 0) begin
                    $error("unexpected word: inverse %0d status %0d", i_inverse, i_status);
                    bad = bad + 1;
                end else begin
                    want = inverse_queue.pop_front();
                    if (want.inverse !== i_inverse) begin
                        $error("inverse: expected %0d actual %0d", want.inverse, i_inverse);
                        bad = bad + 1;
                    end
                    if (want.status !== i_status) begin
                        $error("status: expected %0d actual %0d", want.status, i_status);
                        bad = bad + 1;
                    end
                end
            end
            o_errors <= o_errors + bad;
            o_pending <= inverse_queue.size();
        end
    end

endmodule

[test/tb_modular_inverse.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modular_inverse
// Directed and random words into modular_inverse with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_modular_inverse;

    localparam int N_RANDOM    = 1600;
    localparam int IDLE_LIMIT  = 20000;  // watchdog limit, above the worst word and the long hold
    localparam int DRAIN_WAIT  = 4000;
    localparam int HOLD_CYCLES = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [31:0] i_value = '0;
    logic [31:0] i_modulus = 32'd2;
    logic        i_stall = 1'b0;
    wire         o_stall, o_valid, o_status;
    wire  [31:0] o_inverse;
    int          fail_count, pending_count;
    int          quiet_cycles = 0;
    int          rx_wait = 0;
    bit          hold_long = 1'b0;

    always #4 i_clk = ~i_clk;

    modular_inverse uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_value(i_value), .i_modulus(i_modulus), .o_valid(o_valid),
        .i_stall(i_stall), .o_inverse(o_inverse), .o_status(o_status)
    );

    modular_inverse_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_stall_in(o_stall),
        .i_value(i_value), .i_modulus(i_modulus), .i_ovalid(o_valid),
        .i_ostall(i_stall), .i_inverse(o_inverse), .i_status(o_status),
        .o_errors(fail_count), .o_pending(pending_count)
    );

    // one word: optional gap, then hold valid until accepted
    task automatic send_word(logic [31:0] val, logic [31:0] modv, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            @(posedge i_clk) i_valid <= 1'b0;
            repeat (gap - 1) @(posedge i_clk);
        end
        @(posedge i_clk);
        i_valid <= 1'b1;
        i_value <= val;
        i_modulus <= modv;
        do @(posedge i_clk); while (o_stall);
        i_valid <= 1'b0;
    endtask

    // random operand: up to 300, up to 16 bits, or (half the time) a full 32-bit word
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 300);
            1: return $urandom_range(0, 65535);
            default: return $urandom();
        endcase
    endfunction

    // receiver: random wait after each word, one long hold-off
    always @(posedge i_clk) begin
        if (hold_long) begin
            i_stall <= 1'b1;
        end else if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall)
                rx_wait = $urandom_range(0, 7);
            else if (rx_wait > 0)
                rx_wait = rx_wait - 1;
            i_stall <= (rx_wait > 0);
        end
    end

    // watchdog on cycles with no accepted word
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        logic [31:0] a, m, f;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero value, extremes, common factor, value above modulus,
        // modulus below two, one, inverse of modulus-1
        send_word(32'd0, 32'd7, 0);
        send_word(32'd3, 32'd7, 0);
        send_word(32'd1, 32'd2, 0);
        send_word(32'd6, 32'd9, 0);
        send_word(32'd10, 32'd7, 0);
        send_word(32'd5, 32'd0, 0);
        send_word(32'd5, 32'd1, 0);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_word(32'hFFFF_FFFE, 32'hFFFF_FFFF, 0);
        send_word(32'd2, 32'hFFFF_FFFF, 0);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFE, 0);
        send_word(32'd0, 32'hFFFF_FFFF, 0);
        send_word(32'hB504_F333, 32'hFFFF_FFFB, 0);  // deep Euclid chain
        send_word(32'd1836311903, 32'd2971215073, 0); // Fibonacci pair
        send_word(32'h8000_0000, 32'h7FFF_FFFF, 0);
        send_word(32'd1, 32'd0, 0);

        // sender pauses until every expected word has come
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);

        // long receiver hold-off while words keep coming
        hold_long = 1'b1;
        fork
            begin
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_long = 1'b0;
            end
            for (int k = 0; k < 6; k++) send_word($urandom_range(1, 999), 32'd1009, 0);
        join

        for (int n = 0; n < N_RANDOM; n++) begin
            a = pick_operand();
            m = pick_operand();
            if ($urandom_range(0, 4) == 0) begin
                f = $urandom_range(2, 97);
                a = a * f;
                m = m * f;
            end
            if (m < 2 && $urandom_range(0, 9) != 0) m = m + 2;
            send_word(a, m, (n % 200) < 150);
        end

        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[sim.f]
design/mi_pkg.sv
design/mi_cell.sv
design/mi_chain.sv
design/modular_inverse.sv
test/modular_inverse_checker.sv
test/tb_modular_inverse.sv
